FILE: hw/rtl/rrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_pkg
// Shared constants, register indexes and control types of the mixer.
// ----------------------------------------------------------------------------
package rrm_pkg;

  localparam int INTERP_SHIFT  = 16;
  localparam int POS_FRAC_BITS = 32;
  localparam int ADDR_BITS     = 24;
  localparam int VOL_FRAC_BITS = 16;

  localparam int POS_BITS  = ADDR_BITS + POS_FRAC_BITS;
  localparam int SMP_W     = 8;
  localparam int ACC_W     = 32;
  localparam int VOL_W     = 24;
  localparam int ADDR_W    = 24;
  localparam int CFG_W     = 56;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 3;
  localparam int CNT_W     = 16;
  localparam int IN_W      = 80;
  localparam int OUT_W     = 88;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_MODE        = 3'd0,
    REG_START_POSITION  = 3'd1,
    REG_POSITION_STEP   = 3'd2,
    REG_LEFT_VOL_START  = 3'd3,
    REG_LEFT_VOL_STEP   = 3'd4,
    REG_RIGHT_VOL_START = 3'd5,
    REG_RIGHT_VOL_STEP  = 3'd6,
    REG_FRAME_COUNT     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_MONO   = 2'd0,
    KIND_STEREO = 2'd1,
    KIND_SURR_A = 2'd2,
    KIND_SURR_B = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic interp;
    logic scale;
    logic commit;
  } rrm_cmd_t;

endpackage

FILE: hw/rtl/ramped_resampling_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_resampling_mixer_unit
// A request is taken in the load step and passes the interpolate, scale and
// commit steps before its result is valid. The 4-step sequencer takes one
// request at a time, none before the commit; a result waiting in the output
// register holds the scale step only. Reset (rst, synchronous) restores the
// register defaults and reloads position, volumes and frame counter.
// ----------------------------------------------------------------------------
module ramped_resampling_mixer_unit import rrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sample_here[7:0], sample_next[15:8], acc_left[47:16], acc_right[79:48]
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // mix_left[31:0], mix_right[63:32], next_fetch_address[87:64]
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  rrm_cmd_t cmd;

  rrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  rrm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

FILE: hw/rtl/rrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_ctrl
// Sequencer for one request: load, interpolate, scale, commit to output.
// ----------------------------------------------------------------------------
module rrm_ctrl import rrm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output rrm_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INTERP = 4'b0010,
    ST_SCALE  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_INTERP;
        end
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.scale = 1'b1;
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/rrm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_datapath
// Registers, voice state, interpolation, volume scaling and accumulation.
// ----------------------------------------------------------------------------
module rrm_datapath import rrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rrm_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [IN_W-1:0]      in_data,
  output logic [OUT_W-1:0]     out_data,
  output logic                 out_last
);

  localparam int DIFF_W   = SMP_W + 1;
  localparam int IPROD_W  = DIFF_W + INTERP_SHIFT + 1;
  localparam int SPROD_W  = VOL_W + SMP_W;
  localparam logic [SPROD_W:0] VOL_BIAS = (SPROD_W+1)'((64'd1 << VOL_FRAC_BITS) - 64'd1);
  localparam logic signed [VOL_W:0] VOL_MAX = (VOL_W+1)'((64'd1 << (VOL_W-1)) - 64'd1);
  localparam logic signed [VOL_W:0] VOL_MIN = -(VOL_W+1)'(64'd1 << (VOL_W-1));

  // configuration
  logic [MODE_W-1:0]       mix_mode;
  logic [CFG_W-1:0]        start_position;
  logic [CFG_W-1:0]        position_step;
  logic signed [VOL_W-1:0] left_vol_start, left_vol_step;
  logic signed [VOL_W-1:0] right_vol_start, right_vol_step;
  logic [CNT_W-1:0]        frame_count;

  // voice state
  logic [POS_BITS-1:0]     position;
  logic signed [VOL_W-1:0] left_volume, right_volume;
  logic [CNT_W-1:0]        frames_done;

  // work registers
  logic signed [SMP_W-1:0]   here, nxt;
  logic [ACC_W-1:0]          acc_l, acc_r;
  logic signed [IPROD_W-1:0] iprod;
  logic signed [SPROD_W-1:0] prod_l, prod_r;

  logic signed [VOL_W-1:0]   left_ramp, right_ramp;
  logic signed [DIFF_W-1:0]  diff;
  logic [INTERP_SHIFT-1:0]   frac;
  logic signed [IPROD_W-1:0] iprod_sh;
  logic signed [SMP_W-1:0]   smp;
  logic [ACC_W-1:0]          pl, pr, mix_l, mix_r;
  logic [63:0]               step_ext, start_ext;
  logic [POS_BITS-1:0]       position_next;
  logic [CNT_W-1:0]          frames_inc;
  logic                      last;
  logic [31:0]               addr_ext;
  kind_t                     kind;

  function automatic logic signed [VOL_W-1:0] sat_add(
    input logic signed [VOL_W-1:0] a,
    input logic signed [VOL_W-1:0] b
  );
    logic signed [VOL_W:0] s;
    s = {a[VOL_W-1], a} + {b[VOL_W-1], b};
    if (s > VOL_MAX) begin
      s = VOL_MAX;
    end else if (s < VOL_MIN) begin
      s = VOL_MIN;
    end
    return s[VOL_W-1:0];
  endfunction

  // divide by the volume unit, truncating toward zero
  function automatic logic [ACC_W-1:0] unscale(input logic signed [SPROD_W-1:0] p);
    logic signed [SPROD_W:0] b;
    b = {p[SPROD_W-1], p} + (p[SPROD_W-1] ? $signed(VOL_BIAS) : $signed({(SPROD_W+1){1'b0}}));
    b = b >>> VOL_FRAC_BITS;
    return ACC_W'(b);
  endfunction

  assign left_ramp  = sat_add(left_volume, left_vol_step);
  assign right_ramp = sat_add(right_volume, right_vol_step);

  assign diff     = {nxt[SMP_W-1], nxt} - {here[SMP_W-1], here};
  assign frac     = position[POS_FRAC_BITS-1 -: INTERP_SHIFT];
  assign iprod_sh = iprod >>> INTERP_SHIFT;
  assign smp      = mix_mode[0] ? (here + iprod_sh[SMP_W-1:0]) : here;

  assign kind = kind_t'(mix_mode[MODE_W-1:1]);
  assign pl   = unscale(prod_l);
  assign pr   = unscale(prod_r);

  always_comb begin
    mix_l = acc_l + pl;
    case (kind)
      KIND_MONO:   mix_r = acc_r;
      KIND_STEREO: mix_r = acc_r + pr;
      default:     mix_r = acc_r - pl;
    endcase
  end

  assign step_ext      = {{(64-CFG_W){position_step[CFG_W-1]}}, position_step};
  assign start_ext     = {{(64-CFG_W){1'b0}}, start_position};
  assign position_next = position + step_ext[POS_BITS-1:0];
  assign frames_inc    = frames_done + CNT_W'(1);
  assign last          = (frames_inc == frame_count);
  assign addr_ext      = 32'(position_next[POS_BITS-1:POS_FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode        <= '0;
      start_position  <= '0;
      position_step   <= CFG_W'(64'd1 << POS_FRAC_BITS);
      left_vol_start  <= VOL_W'(64'd1 << VOL_FRAC_BITS);
      left_vol_step   <= '0;
      right_vol_start <= VOL_W'(64'd1 << VOL_FRAC_BITS);
      right_vol_step  <= '0;
      frame_count     <= CNT_W'(1);
      position        <= '0;
      left_volume     <= VOL_W'(64'd1 << VOL_FRAC_BITS);
      right_volume    <= VOL_W'(64'd1 << VOL_FRAC_BITS);
      frames_done     <= '0;
    end else if (cfg_we) begin
      // store the register, then reload the voice state from the set
      case (reg_idx_t'(cfg_index))
        REG_MIX_MODE:        mix_mode        <= cfg_data[MODE_W-1:0];
        REG_START_POSITION:  start_position  <= cfg_data;
        REG_POSITION_STEP:   position_step   <= cfg_data;
        REG_LEFT_VOL_START:  left_vol_start  <= cfg_data[VOL_W-1:0];
        REG_LEFT_VOL_STEP:   left_vol_step   <= cfg_data[VOL_W-1:0];
        REG_RIGHT_VOL_START: right_vol_start <= cfg_data[VOL_W-1:0];
        REG_RIGHT_VOL_STEP:  right_vol_step  <= cfg_data[VOL_W-1:0];
        REG_FRAME_COUNT:     frame_count     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
      case (reg_idx_t'(cfg_index))
        REG_START_POSITION: position <= cfg_data[POS_BITS-1:0];
        default:            position <= start_ext[POS_BITS-1:0];
      endcase
      case (reg_idx_t'(cfg_index))
        REG_LEFT_VOL_START: left_volume <= cfg_data[VOL_W-1:0];
        default:            left_volume <= left_vol_start;
      endcase
      case (reg_idx_t'(cfg_index))
        REG_RIGHT_VOL_START: right_volume <= cfg_data[VOL_W-1:0];
        default:             right_volume <= right_vol_start;
      endcase
      frames_done <= '0;
    end else begin
      if (cmd.load) begin
        left_volume  <= left_ramp;
        right_volume <= right_ramp;
      end
      if (cmd.commit) begin
        position    <= position_next;
        frames_done <= last ? '0 : frames_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      here  <= in_data[7:0];
      nxt   <= in_data[15:8];
      acc_l <= in_data[47:16];
      acc_r <= in_data[79:48];
    end
    if (cmd.interp) begin
      iprod <= diff * $signed({1'b0, frac});
    end
    if (cmd.scale) begin
      prod_l <= left_volume * smp;
      prod_r <= right_volume * smp;
    end
    if (cmd.commit) begin
      out_data <= {addr_ext[ADDR_W-1:0], mix_r, mix_l};
      out_last <= last;
    end
  end

endmodule
